>>> hdl/sct_pkg.sv
package sct_pkg;

  // Word buffer limit and derived counter width
  localparam int MAX_WORD_LEN = 64;
  localparam int CNT_W        = $clog2(MAX_WORD_LEN);
  localparam int LEN_W        = 6;
  localparam int KIND_W       = 4;
  localparam int CHR_W        = 8;

  // Result queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // Result kinds
  localparam logic [KIND_W-1:0] K_WCHAR  = 4'd0;
  localparam logic [KIND_W-1:0] K_WEND   = 4'd1;
  localparam logic [KIND_W-1:0] K_PIPE   = 4'd2;
  localparam logic [KIND_W-1:0] K_INPUT  = 4'd3;
  localparam logic [KIND_W-1:0] K_OUTPUT = 4'd4;
  localparam logic [KIND_W-1:0] K_APPEND = 4'd5;
  localparam logic [KIND_W-1:0] K_BG     = 4'd6;
  localparam logic [KIND_W-1:0] K_END    = 4'd7;
  localparam logic [KIND_W-1:0] K_ERROR  = 4'd8;

  // Special bytes
  localparam logic [CHR_W-1:0] CH_NUL   = 8'd0;
  localparam logic [CHR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHR_W-1:0] CH_PIPE  = 8'h7C;
  localparam logic [CHR_W-1:0] CH_LT    = 8'h3C;
  localparam logic [CHR_W-1:0] CH_GT    = 8'h3E;
  localparam logic [CHR_W-1:0] CH_AMP   = 8'h26;
  localparam logic [CHR_W-1:0] CH_SQ    = 8'h27;
  localparam logic [CHR_W-1:0] CH_DQ    = 8'h22;
  localparam logic [CHR_W-1:0] CH_BSL   = 8'h5C;

  // Quote modes
  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2
  } qmode_t;

  // One result item
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHR_W-1:0]  chr;
    logic [LEN_W-1:0]  word_len;
    logic              last;
  } res_t;

  // Results produced by one byte
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } lex_out_t;

endpackage

>>> hdl/sct_if.sv
interface sct_in_if import sct_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CHR_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface sct_out_if import sct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CHR_W-1:0]  chr;
  logic [LEN_W-1:0]  word_len;
  logic              last;

  modport source (output valid, output kind, output chr, output word_len, output last,
                  input ready);
  modport sink (input valid, input kind, input chr, input word_len, input last,
                output ready);
endinterface

>>> hdl/sct_lexer.sv
module sct_lexer import sct_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [CHR_W-1:0] ch,
  output lex_out_t         res
);

  localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(MAX_WORD_LEN - 1);

  logic             in_word_r, in_word_nxt;
  qmode_t           qmode_r, qmode_nxt;
  logic             esc_r, esc_nxt;
  logic             gt_r, gt_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic do_plain;
  logic s0v, s1v, s2v;
  res_t s0, s1, s2;

  function automatic res_t mk(logic [KIND_W-1:0] k, logic [CHR_W-1:0] c,
                              logic [LEN_W-1:0] l);
    res_t r;
    r.kind     = k;
    r.chr      = c;
    r.word_len = l;
    r.last     = 1'b0;
    return r;
  endfunction

  // Candidate results: lead item, word end, token from plain handling
  always_comb begin
    in_word_nxt = in_word_r;
    qmode_nxt   = qmode_r;
    esc_nxt     = esc_r;
    gt_nxt      = gt_r;
    cnt_nxt     = cnt_r;
    do_plain    = 1'b0;
    s0v = 1'b0; s1v = 1'b0; s2v = 1'b0;
    s0  = '0;   s1  = '0;   s2  = '0;

    if (gt_r) begin
      gt_nxt = 1'b0;
      s0v    = 1'b1;
      if (ch == CH_GT) begin
        s0 = mk(K_APPEND, '0, '0);
      end else begin
        s0       = mk(K_OUTPUT, '0, '0);
        do_plain = 1'b1;
      end
    end else if (esc_r) begin
      esc_nxt = 1'b0;
      if (ch == CH_NUL) begin
        do_plain = 1'b1;
      end else if (cnt_r < CNT_LIM) begin
        s0v     = 1'b1;
        s0      = mk(K_WCHAR, ch, '0);
        cnt_nxt = cnt_r + 1'b1;
      end
    end else if (qmode_r != Q_NONE) begin
      if (ch == CH_NUL) begin
        s0v         = 1'b1;
        s0          = mk(K_ERROR, '0, '0);
        in_word_nxt = 1'b0;
        qmode_nxt   = Q_NONE;
        cnt_nxt     = '0;
      end else if ((qmode_r == Q_SINGLE && ch == CH_SQ) ||
                   (qmode_r == Q_DOUBLE && ch == CH_DQ)) begin
        qmode_nxt = Q_NONE;
      end else if (cnt_r < CNT_LIM) begin
        s0v     = 1'b1;
        s0      = mk(K_WCHAR, ch, '0);
        cnt_nxt = cnt_r + 1'b1;
      end
    end else begin
      do_plain = 1'b1;
    end

    if (do_plain) begin
      case (ch) inside
        CH_NUL, [CH_TAB:CH_CR], CH_SPACE, CH_PIPE, CH_LT, CH_AMP, CH_GT: begin
          // close any open word
          s1v         = in_word_r && (cnt_r != '0);
          s1          = mk(K_WEND, '0, LEN_W'(cnt_r));
          in_word_nxt = 1'b0;
          cnt_nxt     = '0;
          case (ch)
            CH_NUL: begin
              s2v       = 1'b1;
              s2        = mk(K_END, '0, '0);
              qmode_nxt = Q_NONE;
              esc_nxt   = 1'b0;
              gt_nxt    = 1'b0;
            end
            CH_PIPE: begin
              s2v = 1'b1;
              s2  = mk(K_PIPE, '0, '0);
            end
            CH_LT: begin
              s2v = 1'b1;
              s2  = mk(K_INPUT, '0, '0);
            end
            CH_AMP: begin
              s2v = 1'b1;
              s2  = mk(K_BG, '0, '0);
            end
            CH_GT: gt_nxt = 1'b1;
            default: ;
          endcase
        end
        CH_SQ: begin
          in_word_nxt = 1'b1;
          qmode_nxt   = Q_SINGLE;
        end
        CH_DQ: begin
          in_word_nxt = 1'b1;
          qmode_nxt   = Q_DOUBLE;
        end
        CH_BSL: begin
          in_word_nxt = 1'b1;
          esc_nxt     = 1'b1;
        end
        default: begin
          in_word_nxt = 1'b1;
          if (cnt_r < CNT_LIM) begin
            s2v     = 1'b1;
            s2      = mk(K_WCHAR, ch, '0);
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      endcase
    end
  end

  // Pack the first two valid candidates and mark the final one
  always_comb begin
    res = '0;
    if (s0v) begin
      res.r0 = s0;
      if (s1v) begin
        res.r1 = s1;
        res.n  = 2'd2;
      end else if (s2v) begin
        res.r1 = s2;
        res.n  = 2'd2;
      end else begin
        res.n = 2'd1;
      end
    end else if (s1v) begin
      res.r0 = s1;
      if (s2v) begin
        res.r1 = s2;
        res.n  = 2'd2;
      end else begin
        res.n = 2'd1;
      end
    end else if (s2v) begin
      res.r0 = s2;
      res.n  = 2'd1;
    end
    if (res.n == 2'd2) res.r1.last = 1'b1;
    if (res.n == 2'd1) res.r0.last = 1'b1;
  end

  // Advance lexer state on each processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_word_r <= 1'b0;
      qmode_r   <= Q_NONE;
      esc_r     <= 1'b0;
      gt_r      <= 1'b0;
      cnt_r     <= '0;
    end else if (step) begin
      in_word_r <= in_word_nxt;
      qmode_r   <= qmode_nxt;
      esc_r     <= esc_nxt;
      gt_r      <= gt_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule

>>> hdl/sct_res_fifo.sv
module sct_res_fifo import sct_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  lex_out_t  wr,
  output logic      room,
  sct_out_if.source out_res
);

  res_t              mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wp_r, rp_r;
  logic [FCNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]        push_n;
  logic              pop;

  assign push_n = push ? wr.n : 2'd0;
  assign pop    = out_res.valid && out_res.ready;
  assign cnt_nxt = cnt_r + FCNT_W'(push_n) - FCNT_W'(pop);

  // Room for the two results one byte can cause
  assign room = (cnt_r <= FCNT_W'(FIFO_DEPTH - 2));

  // Head of queue drives the result channel
  assign out_res.valid    = (cnt_r != '0);
  assign out_res.kind     = mem_r[rp_r].kind;
  assign out_res.chr      = mem_r[rp_r].chr;
  assign out_res.word_len = mem_r[rp_r].word_len;
  assign out_res.last     = mem_r[rp_r].last;

  // Write up to two entries per cycle
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[wp_r] <= wr.r0;
    if (push_n == 2'd2) mem_r[wp_r + PTR_W'(1)] <= wr.r1;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + PTR_W'(push_n);
      rp_r  <= rp_r + PTR_W'(pop);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hdl/shell_command_tokenizer_top.sv
// Channel   Dir  Payload                          Transfer
// in_ch     in   ch[7:0]                          valid && ready
// out_res   out  kind[3:0] chr[7:0] word_len[5:0]  valid && ready
//                last
//
// Each byte is held in an input register and lexed combinationally into zero,
// one or two results, which go to a four-entry result queue.
// A byte is taken every cycle while the queue has room for two results;
// with two results per byte the single result port limits the rate.
// Synchronous active-low reset clears the lexer state and the queue.
// A stalled result port fills the queue and then holds in_ch.ready low.
module shell_command_tokenizer_top import sct_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sct_in_if.sink    in_ch,
  sct_out_if.source out_res
);

  logic             in_vld_r;
  logic [CHR_W-1:0] in_ch_r;
  logic             room;
  logic             consume;
  lex_out_t         lex_res;

  // Process the held byte when the queue can take its results
  assign consume     = in_vld_r && room;
  assign in_ch.ready = !in_vld_r || consume;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld_r <= 1'b1;
    end else if (consume) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) in_ch_r <= in_ch.ch;
  end

  sct_lexer u_lexer (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (consume),
    .ch    (in_ch_r),
    .res   (lex_res)
  );

  sct_res_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (consume),
    .wr      (lex_res),
    .room    (room),
    .out_res (out_res)
  );

endmodule

>>> hdl/sct_checker.sv
module sct_checker import sct_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] out_kind,
  input logic [CHR_W-1:0]  out_chr,
  input logic [LEN_W-1:0]  out_word_len,
  input logic              out_last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_kind) && $stable(out_chr) && $stable(out_word_len) && $stable(out_last))
    else $error("stalled result changed");

  // Line end and error always close the byte's results
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == K_END || out_kind == K_ERROR) |-> out_last)
    else $error("end or error result not final");

  // Character field carries data only for word characters
  a_chr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_WCHAR |-> out_chr == '0)
    else $error("character set on non-character result");

  // Length field carries data only for word ends
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_WEND |-> out_word_len == '0)
    else $error("length set on non-word-end result");

endmodule

bind shell_command_tokenizer_top sct_checker u_sct_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .out_kind     (out_res.kind),
  .out_chr      (out_res.chr),
  .out_word_len (out_res.word_len),
  .out_last     (out_res.last)
);
